// File: src/cda_pkg.sv
// shared types, constants and calendar helpers for the date adder
package cda_pkg;

  localparam int AMOUNT_BITS = 12;
  localparam int YEAR_BITS   = 16;
  localparam int SUM_W       = ((YEAR_BITS > AMOUNT_BITS) ? YEAR_BITS : AMOUNT_BITS) + 1;

  localparam logic [4:0] DAYS_31  = 5'd31;
  localparam logic [4:0] DAYS_30  = 5'd30;
  localparam logic [4:0] DAYS_29  = 5'd29;
  localparam logic [4:0] DAYS_28  = 5'd28;
  localparam logic [4:0] DAY_ONE  = 5'd1;
  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_APR = 4'd4;
  localparam logic [3:0] MONTH_JUN = 4'd6;
  localparam logic [3:0] MONTH_SEP = 4'd9;
  localparam logic [3:0] MONTH_NOV = 4'd11;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_DAYS   = 2'd1,
    OP_MONTHS = 2'd2,
    OP_YEARS  = 2'd3
  } op_t;

  typedef struct packed {
    op_t                    operation;
    logic [AMOUNT_BITS-1:0] amount;
    logic [4:0]             load_day;
    logic [3:0]             load_month;
    logic [YEAR_BITS-1:0]   load_year;
  } in_item_t;

  typedef struct packed {
    logic [4:0]           out_day;
    logic [3:0]           out_month;
    logic [YEAR_BITS-1:0] out_year;
    logic                 year_overflow;
    logic                 load_error;
  } out_item_t;

  typedef struct packed {
    logic [4:0] day;
    logic [3:0] month;
    logic       year_inc;
  } step_res_t;

  // inverse of an odd number modulo 2^YEAR_BITS, only evaluated on constants
  function automatic logic [YEAR_BITS-1:0] odd_inverse(input logic [YEAR_BITS-1:0] d);
    logic [YEAR_BITS-1:0] x;
    x = d;
    for (int i = 0; i < 5; i++) begin
      x = x * (YEAR_BITS'(2) - d * x);
    end
    return x;
  endfunction

  localparam logic [YEAR_BITS-1:0] YEAR_MAX = {YEAR_BITS{1'b1}};
  localparam logic [YEAR_BITS-1:0] INV25    = odd_inverse(YEAR_BITS'(25));
  localparam logic [YEAR_BITS-1:0] LIM25    = YEAR_MAX / YEAR_BITS'(25);

  // zero for a month code outside january..december
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    if (m < MONTH_JAN || m > MONTH_DEC) begin
      len = 5'd0;
    end else if (m == MONTH_FEB) begin
      len = leap ? DAYS_29 : DAYS_28;
    end else if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV) begin
      len = DAYS_30;
    end else begin
      len = DAYS_31;
    end
    return len;
  endfunction

endpackage

// File: src/cda_leap.sv
// leap year test by the 4/100/400 rule
module cda_leap (
  input  logic [cda_pkg::YEAR_BITS-1:0] year,
  output logic                          leap
);
  import cda_pkg::*;

  logic [YEAR_BITS-1:0] prod;
  logic                 div25;

  // odd divisor test: y*inv(25) mod 2^n stays small exactly for multiples of 25
  assign prod  = year * INV25;
  assign div25 = (prod <= LIM25);
  assign leap  = (year[1:0] == 2'b00) && (!div25 || (year[3:0] == 4'b0000));

endmodule

// File: src/cda_step.sv
// one day or one month step of the held date
module cda_step (
  input  logic                 month_mode,
  input  logic [4:0]           day,
  input  logic [3:0]           month,
  input  logic                 leap,
  output cda_pkg::step_res_t   res
);
  import cda_pkg::*;

  logic [4:0] cur_len;
  logic [4:0] new_len;
  logic [3:0] next_month;
  logic       wrap;

  assign wrap       = (month >= MONTH_DEC);
  assign next_month = wrap ? MONTH_JAN : month + 4'd1;
  assign cur_len    = month_len(month, leap);
  // after a wrap the month is january, so the old year's leap flag does no harm
  assign new_len    = month_len(next_month, leap);

  always_comb begin
    res = '0;
    if (month_mode) begin
      res.month    = next_month;
      res.year_inc = wrap;
      res.day      = (day > new_len) ? new_len : day;
    end else if (day >= cur_len) begin
      res.day      = DAY_ONE;
      res.month    = next_month;
      res.year_inc = wrap;
    end else begin
      res.day      = day + 5'd1;
      res.month    = month;
      res.year_inc = 1'b0;
    end
  end

endmodule

// File: src/calendar_date_adder_unit.sv
// calendar date adder: holds a date and loads it or adds days, months or years
//
// Usage: drive in_item and raise start; the command transfers at a clock edge
// where start is high and busy is low. busy stays high until the result has
// been shown. The result appears on out_item for exactly one cycle with
// out_valid high; the receiver cannot stall it and must take it then.
// Steps from the transfer edge to the out_valid cycle:
//   load               validate, show
//   add years          leap refresh, show
//   add days / months  one step per day or month of the amount, and a leap
//                      refresh after each new year entered, then show;
//                      an amount of zero goes straight to show
// The single step unit moves the date one day or month a cycle, pausing
// for each leap refresh.
// A new command is taken the cycle after out_valid.
// Reset (rst_n low, synchronous) sets the date to 1 January of year 0 and
// drops busy and out_valid.
module calendar_date_adder_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  cda_pkg::in_item_t  in_item,
  output logic               out_valid,
  output cda_pkg::out_item_t out_item
);
  import cda_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LDCHK = 5'b00010,
    S_STEP  = 5'b00100,
    S_LEAP  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [4:0]             day_r, day_nxt;
  logic [3:0]             month_r, month_nxt;
  logic [YEAR_BITS-1:0]   year_r, year_nxt;
  logic                   leap_r, leap_nxt;
  logic                   ovf_r, ovf_nxt;
  logic                   err_r, err_nxt;
  logic [AMOUNT_BITS-1:0] cnt_r, cnt_nxt;
  op_t                    op_r, op_nxt;
  logic [4:0]             ld_day_r, ld_day_nxt;
  logic [3:0]             ld_month_r, ld_month_nxt;
  logic [YEAR_BITS-1:0]   ld_year_r, ld_year_nxt;

  logic [YEAR_BITS-1:0]   leap_year_in;
  logic                   leap_calc;
  step_res_t              step;
  logic [4:0]             ld_len;
  logic                   ld_ok;
  logic [SUM_W-1:0]       year_sum;

  assign leap_year_in = (state_r == S_LDCHK) ? ld_year_r : year_r;

  cda_leap u_leap (
    .year (leap_year_in),
    .leap (leap_calc)
  );

  cda_step u_step (
    .month_mode (op_r == OP_MONTHS),
    .day        (day_r),
    .month      (month_r),
    .leap       (leap_r),
    .res        (step)
  );

  assign ld_len   = month_len(ld_month_r, leap_calc);
  assign ld_ok    = (ld_len != 5'd0) && (ld_day_r != 5'd0) && (ld_day_r <= ld_len);
  assign year_sum = SUM_W'(year_r) + SUM_W'(in_item.amount);

  always_comb begin
    state_nxt    = state_r;
    day_nxt      = day_r;
    month_nxt    = month_r;
    year_nxt     = year_r;
    leap_nxt     = leap_r;
    ovf_nxt      = ovf_r;
    err_nxt      = err_r;
    cnt_nxt      = cnt_r;
    op_nxt       = op_r;
    ld_day_nxt   = ld_day_r;
    ld_month_nxt = ld_month_r;
    ld_year_nxt  = ld_year_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt       = in_item.operation;
          ld_day_nxt   = in_item.load_day;
          ld_month_nxt = in_item.load_month;
          ld_year_nxt  = in_item.load_year;
          ovf_nxt      = 1'b0;
          err_nxt      = 1'b0;
          cnt_nxt      = in_item.amount;
          case (in_item.operation)
            OP_LOAD: begin
              state_nxt = S_LDCHK;
            end
            OP_YEARS: begin
              cnt_nxt   = '0;
              year_nxt  = year_sum[YEAR_BITS-1:0];
              ovf_nxt   = |year_sum[SUM_W-1:YEAR_BITS];
              state_nxt = S_LEAP;
            end
            default: begin
              state_nxt = (in_item.amount == '0) ? S_DONE : S_STEP;
            end
          endcase
        end
      end
      S_LDCHK: begin
        if (ld_ok) begin
          day_nxt   = ld_day_r;
          month_nxt = ld_month_r;
          year_nxt  = ld_year_r;
          leap_nxt  = leap_calc;
        end else begin
          err_nxt = 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_STEP: begin
        day_nxt   = step.day;
        month_nxt = step.month;
        cnt_nxt   = cnt_r - AMOUNT_BITS'(1);
        if (step.year_inc) begin
          year_nxt  = year_r + YEAR_BITS'(1);
          ovf_nxt   = ovf_r | (year_r == YEAR_MAX);
          state_nxt = S_LEAP;
        end else if (cnt_r == AMOUNT_BITS'(1)) begin
          state_nxt = S_DONE;
        end
      end
      S_LEAP: begin
        // refresh the leap flag for the new year before any further step
        leap_nxt  = leap_calc;
        state_nxt = (cnt_r != '0) ? S_STEP : S_DONE;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      day_r   <= DAY_ONE;
      month_r <= MONTH_JAN;
      year_r  <= '0;
      leap_r  <= 1'b1;
      ovf_r   <= 1'b0;
      err_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      day_r   <= day_nxt;
      month_r <= month_nxt;
      year_r  <= year_nxt;
      leap_r  <= leap_nxt;
      ovf_r   <= ovf_nxt;
      err_r   <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    op_r       <= op_nxt;
    ld_day_r   <= ld_day_nxt;
    ld_month_r <= ld_month_nxt;
    ld_year_r  <= ld_year_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

  always_comb begin
    out_item.out_day       = day_r;
    out_item.out_month     = month_r;
    out_item.out_year      = year_r;
    out_item.year_overflow = ovf_r;
    out_item.load_error    = err_r;
  end

endmodule
